[src/prtm_pkg.sv]
// Shared types and constants for the pointer range table match block.
`default_nettype none
package prtm_pkg;

  // Table geometry default.
  localparam int MAX_RANGES_DEF = 64;

  // Field widths fixed by the beat formats.
  localparam int ADDR_W  = 64;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  // Configuration port geometry: registers sit at 8-byte strides.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  // Offset value that disables the preset-offset compare.
  localparam logic [ADDR_W-1:0] NO_PRESET = '1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_PROBE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_PRESET_MODE   = 2'd0,
    REG_PRESET_OFFSET = 2'd1,
    REG_RANGE_COUNT   = 2'd2
  } reg_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic               exact;
    logic [ADDR_W-1:0]  offset;
    logic [COUNT_W-1:0] count;
  } cfg_t;

endpackage
`default_nettype wire

[src/prtm_if.sv]
// Handshake interfaces for the probe/write input channel and the match result channel.
`default_nettype none
interface prtm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [prtm_pkg::INDEX_W-1:0]  entry_index;
  logic [prtm_pkg::ADDR_W-1:0]   range_start;
  logic [prtm_pkg::ADDR_W-1:0]   range_end;
  logic [prtm_pkg::ADDR_W-1:0]   word_addr;
  logic [prtm_pkg::ADDR_W-1:0]   word_value;

  modport source (
    output valid, operation, entry_index, range_start, range_end, word_addr, word_value,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, range_start, range_end, word_addr, word_value,
    output ready
  );
endinterface

interface prtm_out_if;
  logic                          valid;
  logic                          ready;
  logic [prtm_pkg::INDEX_W-1:0]  hit_index;
  logic [prtm_pkg::ADDR_W-1:0]   found_addr;
  logic [prtm_pkg::ADDR_W-1:0]   found_value;

  modport source (
    output valid, hit_index, found_addr, found_value,
    input  ready
  );
  modport sink (
    input  valid, hit_index, found_addr, found_value,
    output ready
  );
endinterface
`default_nettype wire

[src/pointer_range_table_match.sv]
// Top level of the pointer range table match block: pipeline control and output register.
`default_nettype none
// Pointer range table match. Write beats (operation 0) load entry entry_index of a table of
// MAX_RANGES (start, end) pairs; probe beats (operation 1) compare word_value against
// entries 0 .. range_count-1 (range_count saturates at MAX_RANGES) and return one result
// beat with the lowest matching entry, or nothing. Range mode matches start <= word <= end;
// with preset_mode set and preset_offset not all-ones, an entry matches when
// word == end - preset_offset (mod 2^64). The table is held in flip-flops and every entry
// is compared in parallel, so a beat enters every cycle unless the pipeline stalls, and
// a probe's result is offered once it has passed four register stages: input register
// with the offset add, compare lanes, first priority level, output register. Writes land
// in the table as they leave the first stage, in order with probes. Entries never written
// read as undefined. Each stage holds only while the one after it is full and stalled, so
// bubbles close up under back-pressure.
// The user must make configuration writes only while no beat is in flight (unchecked).
module pointer_range_table_match #(
  parameter int MAX_RANGES = prtm_pkg::MAX_RANGES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  prtm_in_if.sink                                in_ch,
  prtm_out_if.source                             out_ch,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [prtm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [prtm_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [prtm_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W = ($clog2(MAX_RANGES + 1) > prtm_pkg::COUNT_W) ?
                         $clog2(MAX_RANGES + 1) : prtm_pkg::COUNT_W;

  prtm_pkg::cfg_t cfg;
  logic [CNT_W-1:0] cnt_ext;
  logic [CNT_W-1:0] count_sat;

  // Stage 1: input register.
  logic                          s1_valid_r, s1_valid_nxt;
  prtm_pkg::op_e                 s1_op_r;
  logic [prtm_pkg::INDEX_W-1:0]  s1_idx_r;
  logic [prtm_pkg::ADDR_W-1:0]   s1_start_r, s1_end_r, s1_addr_r, s1_word_r, s1_key_r;
  // Stage 2: hit vector (in the table).
  logic                          s2_valid_r, s2_valid_nxt;
  logic [prtm_pkg::ADDR_W-1:0]   s2_addr_r, s2_word_r;
  // Stage 3: group priority (in the encoder).
  logic                          s3_valid_r, s3_valid_nxt;
  logic [prtm_pkg::ADDR_W-1:0]   s3_addr_r, s3_word_r;
  // Stage 4: output register.
  logic                          s4_valid_r, s4_valid_nxt;
  logic [IDX_W-1:0]              s4_idx_r;
  logic [prtm_pkg::ADDR_W-1:0]   s4_addr_r, s4_word_r;

  logic                          en1, en2, en3, en4;
  logic                          s1_is_write;
  logic [MAX_RANGES-1:0]         hit;
  logic                          any_hit;
  logic [IDX_W-1:0]              hit_idx;

  prtm_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  // Saturate the entry count at the table size.
  always_comb begin
    cnt_ext = CNT_W'(cfg.count);
    if (cnt_ext > CNT_W'(MAX_RANGES)) begin
      count_sat = CNT_W'(MAX_RANGES);
    end else begin
      count_sat = cnt_ext;
    end
  end

  // A write beat always drains out of stage 1: it updates the table and goes no further.
  assign s1_is_write = (s1_op_r == prtm_pkg::OP_WRITE);

  // A stage advances if empty or if the next advances; stage 1 also if it holds a write.
  assign en4 = !s4_valid_r || out_ch.ready;
  assign en3 = !s3_valid_r || en4;
  assign en2 = !s2_valid_r || en3;
  assign en1 = !s1_valid_r || en2 || s1_is_write;

  assign in_ch.ready = en1;

  always_comb begin
    s1_valid_nxt = en1 ? in_ch.valid : s1_valid_r;
    s2_valid_nxt = en2 ? (s1_valid_r && !s1_is_write) : s2_valid_r;
    s3_valid_nxt = en3 ? s2_valid_r : s3_valid_r;
    // Drop a probe that hit nothing.
    s4_valid_nxt = en4 ? (s3_valid_r && any_hit) : s4_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
      s4_valid_r <= s4_valid_nxt;
    end
  end

  // Payload registers: hold unless the stage advances.
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op_r    <= prtm_pkg::op_e'(in_ch.operation);
      s1_idx_r   <= in_ch.entry_index;
      s1_start_r <= in_ch.range_start;
      s1_end_r   <= in_ch.range_end;
      s1_addr_r  <= in_ch.word_addr;
      s1_word_r  <= in_ch.word_value;
      s1_key_r   <= in_ch.word_value + cfg.offset;
    end
    if (en2) begin
      s2_addr_r <= s1_addr_r;
      s2_word_r <= s1_word_r;
    end
    if (en3) begin
      s3_addr_r <= s2_addr_r;
      s3_word_r <= s2_word_r;
    end
    if (en4) begin
      s4_idx_r  <= hit_idx;
      s4_addr_r <= s3_addr_r;
      s4_word_r <= s3_word_r;
    end
  end

  prtm_table #(
    .MAX_RANGES(MAX_RANGES),
    .CNT_W     (CNT_W)
  ) u_table (
    .clk      (clk),
    .wr_en    (s1_valid_r && s1_is_write),
    .wr_idx   (s1_idx_r),
    .wr_start (s1_start_r),
    .wr_end   (s1_end_r),
    .cmp_en   (en2),
    .exact    (cfg.exact),
    .count_sat(count_sat),
    .word     (s1_word_r),
    .key      (s1_key_r),
    .hit_r    (hit)
  );

  prtm_prio #(
    .MAX_RANGES(MAX_RANGES),
    .IDX_W     (IDX_W)
  ) u_prio (
    .clk(clk),
    .en (en3),
    .hit(hit),
    .any(any_hit),
    .idx(hit_idx)
  );

  assign out_ch.valid       = s4_valid_r;
  assign out_ch.hit_index   = prtm_pkg::INDEX_W'(s4_idx_r);
  assign out_ch.found_addr  = s4_addr_r;
  assign out_ch.found_value = s4_word_r;

`ifndef SYNTHESIS
  // Reset empties every stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !s2_valid_r && !s3_valid_r && !s4_valid_r)
    else $error("pipeline not empty after reset");

  // A write in stage 1 never blocks the input.
  a_write_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_is_write) |-> in_ch.ready)
    else $error("write beat stalled in stage 1");

  // A result only appears from a probe that sat in stage 3.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(s4_valid_r) |-> $past(s3_valid_r) && $past(any_hit))
    else $error("result without a matching probe");

  // A reported entry lies below the active entry count.
  a_index_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r |-> (CNT_W'(s4_idx_r) < count_sat))
    else $error("hit index beyond range count");
`endif

endmodule
`default_nettype wire

[src/prtm_cfg.sv]
// APB-style configuration registers for the pointer range table match block.
`default_nettype none
module prtm_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [prtm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [prtm_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [prtm_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                   cfg_pready,
  output prtm_pkg::cfg_t                         cfg
);

  logic                              mode_r;
  logic [prtm_pkg::ADDR_W-1:0]       offset_r;
  logic [prtm_pkg::COUNT_W-1:0]      count_r;
  logic                              wr_fire;
  prtm_pkg::reg_e                    reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_fire    = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_sel    = prtm_pkg::reg_e'(cfg_paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      offset_r <= '0;
      count_r  <= '0;
    end else if (wr_fire) begin
      unique case (reg_sel)
        prtm_pkg::REG_PRESET_MODE:   mode_r   <= cfg_pwdata[0];
        prtm_pkg::REG_PRESET_OFFSET: offset_r <= cfg_pwdata;
        prtm_pkg::REG_RANGE_COUNT:   count_r  <= cfg_pwdata[prtm_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      prtm_pkg::REG_PRESET_MODE:   cfg_prdata = prtm_pkg::CFG_DATA_W'(mode_r);
      prtm_pkg::REG_PRESET_OFFSET: cfg_prdata = offset_r;
      prtm_pkg::REG_RANGE_COUNT:   cfg_prdata = prtm_pkg::CFG_DATA_W'(count_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  // All-ones offset falls back to range compare.
  assign cfg.exact  = mode_r & (offset_r != prtm_pkg::NO_PRESET);
  assign cfg.offset = offset_r;
  assign cfg.count  = count_r;

endmodule
`default_nettype wire

[src/prtm_table.sv]
// Range table storage and per-entry compare lanes with a registered hit vector.
`default_nettype none
module prtm_table #(
  parameter int MAX_RANGES = prtm_pkg::MAX_RANGES_DEF,
  parameter int CNT_W      = 7
) (
  input  wire logic                              clk,
  input  wire logic                              wr_en,
  input  wire logic [prtm_pkg::INDEX_W-1:0]      wr_idx,
  input  wire logic [prtm_pkg::ADDR_W-1:0]       wr_start,
  input  wire logic [prtm_pkg::ADDR_W-1:0]       wr_end,
  input  wire logic                              cmp_en,
  input  wire logic                              exact,
  input  wire logic [CNT_W-1:0]                  count_sat,
  input  wire logic [prtm_pkg::ADDR_W-1:0]       word,
  input  wire logic [prtm_pkg::ADDR_W-1:0]       key,
  output logic      [MAX_RANGES-1:0]             hit_r
);

  logic [prtm_pkg::ADDR_W-1:0] start_r [MAX_RANGES];
  logic [prtm_pkg::ADDR_W-1:0] end_r   [MAX_RANGES];
  logic [MAX_RANGES-1:0]       hit_nxt;

  // One lane per entry; an index beyond the table matches no lane.
  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (wr_en && (int'(wr_idx) == i)) begin
        start_r[i] <= wr_start;
        end_r[i]   <= wr_end;
      end
    end

    // Exact mode: end - offset == word, checked as end == word + offset.
    always_comb begin
      if (CNT_W'(i) >= count_sat) begin
        hit_nxt[i] = 1'b0;
      end else if (exact) begin
        hit_nxt[i] = (end_r[i] == key);
      end else begin
        hit_nxt[i] = (start_r[i] <= word) && (word <= end_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      hit_r <= hit_nxt;
    end
  end

endmodule
`default_nettype wire

[src/prtm_prio.sv]
// Two-level lowest-index priority encoder over the hit vector, first level registered.
`default_nettype none
module prtm_prio #(
  parameter int MAX_RANGES = prtm_pkg::MAX_RANGES_DEF,
  parameter int IDX_W      = 6
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [MAX_RANGES-1:0] hit,
  output logic                       any,
  output logic      [IDX_W-1:0]      idx
);

  localparam int GRP  = 8;
  localparam int G    = (MAX_RANGES + GRP - 1) / GRP;
  localparam int GW   = (G > 1) ? $clog2(G) : 1;
  localparam int PAD  = G * GRP;
  localparam int FW   = GW + 3;

  logic [PAD-1:0] hit_pad;
  logic [G-1:0]   grp_any_nxt;
  logic [2:0]     grp_sub_nxt [G];
  logic [G-1:0]   grp_any_r;
  logic [2:0]     grp_sub_r [G];
  logic [FW-1:0]  idx_full;

  assign hit_pad = PAD'(hit);

  // First level: per group of eight, flag any hit and the lowest one.
  for (genvar g = 0; g < G; g++) begin : g_grp
    always_comb begin
      grp_any_nxt[g] = |hit_pad[g*GRP +: GRP];
      grp_sub_nxt[g] = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if (hit_pad[g*GRP + j]) begin
          grp_sub_nxt[g] = 3'(j);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        grp_any_r[g] <= grp_any_nxt[g];
        grp_sub_r[g] <= grp_sub_nxt[g];
      end
    end
  end

  // Second level: lowest group that hit.
  always_comb begin
    idx_full = '0;
    for (int g = G - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        idx_full = {GW'(g), grp_sub_r[g]};
      end
    end
  end

  assign any = |grp_any_r;
  assign idx = IDX_W'(idx_full);

endmodule
`default_nettype wire

[sim/tb_pointer_range_table_match.sv]
// Self-checking testbench for pointer_range_table_match: writes and probes, directed then random.
`timescale 1ns / 1ps
module tb_pointer_range_table_match;
  import prtm_pkg::*;

  localparam int TABLE_DEPTH  = MAX_RANGES_DEF;
  // The block is four stages deep; give a probe that finds nothing time to drop out
  // before any register changes.
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_BEATS  = 70;
  localparam int RAND_PHASES  = 8;

  // One beat of the input channel, as the stimulus sees it.
  typedef struct {
    op_e                op;
    logic [INDEX_W-1:0] idx;
    logic [ADDR_W-1:0]  lo;
    logic [ADDR_W-1:0]  hi;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  word;
  } in_beat_t;

  // One beat of the result channel.
  typedef struct {
    logic [INDEX_W-1:0] parent;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  word;
  } match_t;

  // Mirror of the range table and the register file, plus the queue of matches
  // that accepted probes are owed.
  class match_scoreboard;
    logic [ADDR_W-1:0]  start_tbl [TABLE_DEPTH];
    logic [ADDR_W-1:0]  end_tbl   [TABLE_DEPTH];
    logic               preset_mode;
    logic [ADDR_W-1:0]  offset;
    logic [COUNT_W-1:0] count;
    match_t             match_q [$];
    int                 errors;
    int                 writes;
    int                 probes;
    int                 checked;
    int                 settings;

    function new();
      preset_mode = 1'b0;
      offset      = '0;
      count       = '0;
      errors      = 0;
      writes      = 0;
      probes      = 0;
      checked     = 0;
      settings    = 0;
    endfunction

    function void set_reg(reg_e r, logic [CFG_DATA_W-1:0] v);
      settings++;
      case (r)
        REG_PRESET_MODE:   preset_mode = v[0];
        REG_PRESET_OFFSET: offset = v[ADDR_W-1:0];
        REG_RANGE_COUNT:   count = v[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // A count above the table size clamps to the table size.
    function int live_entries();
      return (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
    endfunction

    // The all-ones offset means no preset at this depth: fall back to range compare.
    function bit exact_compare();
      return preset_mode && (offset != NO_PRESET);
    endfunction

    function void note_beat(in_beat_t b);
      int     live;
      bit     exact;
      bit     hit;
      match_t m;
      if (b.op == OP_WRITE) begin
        start_tbl[b.idx] = b.lo;
        end_tbl[b.idx]   = b.hi;
        writes++;
        return;
      end
      probes++;
      live  = live_entries();
      exact = exact_compare();
      for (int i = 0; i < live; i++) begin
        if (exact)
          hit = (b.word == end_tbl[i] - offset);
        else
          hit = (b.word >= start_tbl[i]) && (b.word <= end_tbl[i]);
        if (hit) begin
          m.parent = INDEX_W'(i);
          m.addr   = b.addr;
          m.word   = b.word;
          match_q  = {match_q, m};
          return;
        end
      end
    endfunction

    function void check_result(match_t got);
      match_t want;
      checked++;
      if (match_q.size() == 0) begin
        $error("result beat with no match pending: hit_index %0d found_addr %h found_value %h",
               got.parent, got.addr, got.word);
        errors++;
        return;
      end
      want = match_q.pop_front();
      if (got.parent !== want.parent) begin
        $error("hit_index: expected %0d, actual %0d", want.parent, got.parent);
        errors++;
      end
      if (got.addr !== want.addr) begin
        $error("found_addr: expected %h, actual %h", want.addr, got.addr);
        errors++;
      end
      if (got.word !== want.word) begin
        $error("found_value: expected %h, actual %h", want.word, got.word);
        errors++;
      end
    endfunction

    function int pending();
      return match_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  prtm_in_if  in_ch ();
  prtm_out_if out_ch ();

  match_scoreboard sb = new();

  // Set by the main sequence only: steady drops all idling on both sides,
  // want_hold asks the result sink for one long hold-off.
  bit steady;
  bit want_hold;
  // Set by the result sink only.
  bit hold_used;
  int cycle_count;

  pointer_range_table_match u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Timeout: a hung handshake ends the run here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_beat_t entry_beat(input int slot, input logic [ADDR_W-1:0] lo,
                                          input logic [ADDR_W-1:0] hi);
    in_beat_t b;
    b.op   = OP_WRITE;
    b.idx  = INDEX_W'(slot);
    b.lo   = lo;
    b.hi   = hi;
    // A write ignores the probe fields; keep them noisy.
    b.addr = rand64();
    b.word = rand64();
    return b;
  endfunction

  function automatic in_beat_t probe_beat(input logic [ADDR_W-1:0] word,
                                          input logic [ADDR_W-1:0] addr);
    in_beat_t b;
    b.op   = OP_PROBE;
    // A probe ignores the entry fields; keep them noisy.
    b.idx  = INDEX_W'($urandom);
    b.lo   = rand64();
    b.hi   = rand64();
    b.addr = addr;
    b.word = word;
    return b;
  endfunction

  // Random entry: mostly narrow ranges, some single addresses, some random pairs
  // (half of those inverted, so they never match in range mode).
  function automatic in_beat_t random_entry(input int slot);
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    lo = rand64();
    case ($urandom_range(0, 9))
      0, 1:    hi = rand64();
      2:       hi = lo;
      default: hi = lo + ADDR_W'($urandom_range(0, 4096));
    endcase
    return entry_beat(slot, lo, hi);
  endfunction

  // Random probe aimed at a live entry most of the time, so most probes hit.
  function automatic in_beat_t random_probe();
    in_beat_t          b;
    int                live;
    int                k;
    logic [ADDR_W-1:0] span;
    b    = probe_beat(rand64(), rand64());
    live = sb.live_entries();
    case ($urandom_range(0, 15))
      0:       b.addr = '0;
      1:       b.addr = '1;
      default: ;
    endcase
    if (live > 0) begin
      k    = $urandom_range(0, live - 1);
      span = sb.end_tbl[k] - sb.start_tbl[k];
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        3:       b.word = sb.start_tbl[k] - 1'b1;
        4:       b.word = sb.end_tbl[k] + 1'b1;
        5:       b.word = sb.exact_compare() ? sb.end_tbl[k] - sb.offset : sb.start_tbl[k];
        default: begin
          if (sb.exact_compare())
            b.word = sb.end_tbl[k] - sb.offset;
          else if (sb.start_tbl[k] <= sb.end_tbl[k] && span != '1)
            b.word = sb.start_tbl[k] + (rand64() % (span + 1'b1));
        end
      endcase
    end
    return b;
  endfunction

  // Offer one beat after a random gap and hold it until the block takes it.
  // Valid stays high into the next beat when that one has no gap.
  task automatic send_beat(input in_beat_t b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= b.op;
    in_ch.entry_index <= b.idx;
    in_ch.range_start <= b.lo;
    in_ch.range_end   <= b.hi;
    in_ch.word_addr   <= b.addr;
    in_ch.word_value  <= b.word;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_beat(b);
  endtask

  // Setup cycle, access cycle, then an idle gap so back-to-back writes never
  // lower and raise psel at the same edge.
  task automatic cfg_write(input reg_e r, input logic [CFG_DATA_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 3'b000};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_reg(r, v);
    @(posedge clk);
  endtask

  // Drop valid, wait for every owed match, then let non-matching probes drain.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result sink: random stall after each beat, plus one long hold-off on request.
  initial begin : result_sink
    int     stall;
    int     hold;
    match_t got;
    stall = 0;
    hold  = 0;
    hold_used = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.parent = out_ch.hit_index;
        got.addr   = out_ch.found_addr;
        got.word   = out_ch.found_value;
        sb.check_result(got);
        stall = steady ? 0 : $urandom_range(0, 5);
      end
      if (want_hold && !hold_used) begin
        hold      = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : main_seq
    logic               mode;
    logic [ADDR_W-1:0]  ofs;
    logic [COUNT_W-1:0] cnt;
    steady    = 1'b0;
    want_hold = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_WRITE;
    in_ch.entry_index <= '0;
    in_ch.range_start <= '0;
    in_ch.range_end   <= '0;
    in_ch.word_addr   <= '0;
    in_ch.word_value  <= '0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: registers at their reset values, written explicitly.
    cfg_write(REG_PRESET_MODE, 0);
    cfg_write(REG_PRESET_OFFSET, 0);
    cfg_write(REG_RANGE_COUNT, 0);

    // Empty table: a probe compares nothing and returns nothing.
    send_beat(probe_beat('1, '1));
    // Point range, ordinary range, inverted range, whole space, top entry at the extremes.
    send_beat(entry_beat(0, 64'd0, 64'd0));
    send_beat(entry_beat(1, 64'd10, 64'd20));
    send_beat(entry_beat(2, 64'd30, 64'd25));
    send_beat(entry_beat(3, 64'd0, '1));
    send_beat(entry_beat(63, '1 - 64'd1, '1));
    settle();
    cfg_write(REG_RANGE_COUNT, 4);

    // Range mode: lowest index wins; inverted entry never matches.
    send_beat(probe_beat(64'd0, '0));
    send_beat(probe_beat(64'd10, '1));
    send_beat(probe_beat(64'd20, 64'h1234));
    send_beat(probe_beat(64'd21, rand64()));
    send_beat(probe_beat(64'd27, rand64()));
    send_beat(probe_beat('1, rand64()));
    settle();

    // Exact mode: end minus offset, wrapping below zero for entry 0.
    cfg_write(REG_PRESET_MODE, 1);
    cfg_write(REG_PRESET_OFFSET, 5);
    send_beat(probe_beat(64'd15, rand64()));
    send_beat(probe_beat('1 - 64'd4, rand64()));
    send_beat(probe_beat('1 - 64'd5, rand64()));
    send_beat(probe_beat(64'd20, rand64()));
    settle();

    // All-ones offset: no preset at this depth, so range compare despite preset_mode.
    cfg_write(REG_PRESET_OFFSET, NO_PRESET);
    send_beat(probe_beat(64'd15, rand64()));
    send_beat(probe_beat(64'd27, rand64()));
    settle();

    // Fill every entry before any count above the directed four goes live.
    steady = 1'b1;
    for (int i = 0; i < TABLE_DEPTH; i++) send_beat(random_entry(i));
    steady = 1'b0;
    settle();

    // Random phases, each under its own register setting, extremes included.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin mode = 1'b0; ofs = rand64();                        cnt = 7'd64;  end
        1: begin mode = 1'b1; ofs = '0;                              cnt = 7'd1;   end
        2: begin mode = 1'b1; ofs = rand64();                        cnt = 7'd127; end
        3: begin mode = 1'b1; ofs = NO_PRESET;                       cnt = 7'd64;  end
        4: begin mode = 1'b0; ofs = '1 - 64'd1;                      cnt = 7'd63;  end
        5: begin mode = 1'b1; ofs = ADDR_W'($urandom_range(1, 4096)); cnt = 7'd100; end
        6: begin mode = 1'b1; ofs = NO_PRESET - 64'd1;               cnt = 7'd33;  end
        default: begin
          mode = 1'b0;
          ofs  = '0;
          cnt  = COUNT_W'($urandom_range(1, TABLE_DEPTH));
        end
      endcase
      cfg_write(REG_PRESET_MODE, mode);
      cfg_write(REG_PRESET_OFFSET, ofs);
      cfg_write(REG_RANGE_COUNT, cnt);
      // Every third phase runs with no idling on either side.
      steady = (p % 3 == 1);
      // Hold the result side off while the sender keeps pushing, so the block backs up.
      if (p == 2) want_hold = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(0, 99) < 15)
          send_beat(random_entry($urandom_range(0, TABLE_DEPTH - 1)));
        else
          send_beat(random_probe());
      end
      settle();
    end

    $display("Covered %0d table writes and %0d probes; %0d match beats checked.",
             sb.writes, sb.probes, sb.checked);
    $display("Used %0d register writes over range, exact and no-preset modes, %0d-cycle hold-off.",
             sb.settings, HOLD_CYCLES);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
